/* rtl/stt_pkg.sv */
// Package: shared types and codes for the software timer table.
package stt_pkg;
    localparam int unsigned ID_W   = 32;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned PER_W  = 32;

    typedef enum logic [1:0] {
        t_OP_ADD  = 2'd0,
        t_OP_DEL  = 2'd1,
        t_OP_TICK = 2'd2,
        t_OP_NONE = 2'd3
    } t_op;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_DEL   = 2'd1;
    localparam logic [1:0] KIND_EXP   = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        t_ST_IDLE = 2'd0,
        t_ST_SCAN = 2'd1,
        t_ST_DONE = 2'd2
    } t_state;

    // slot contents as they rotate through the ring
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
        logic [PER_W-1:0]  period;
    } t_slot;
endpackage

/* rtl/stt_cell.sv */
// Cell: one slot register of the rotating timer ring.
module stt_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  stt_pkg::t_slot i_slot,
    output stt_pkg::t_slot o_slot
);
    stt_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;
endmodule

/* rtl/stt_ctrl.sv */
// Controller: processes the slot leaving the ring head and emits results.
module stt_ctrl #(
    parameter int unsigned SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_operation,
    input  logic [31:0]                 i_delay_ms,
    input  logic [31:0]                 i_period_ms,
    input  logic [31:0]                 i_timer_id,
    input  stt_pkg::t_slot              i_head,
    output stt_pkg::t_slot              o_tail,
    output logic                        o_shift,
    output logic                        o_busy,
    output logic                        o_strobe,
    output logic [1:0]                  o_kind,
    output logic [31:0]                 o_result_id,
    output logic                        o_success,
    output logic                        o_reloaded,
    output logic                        o_last_result
);
    localparam int unsigned CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    stt_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_op;
    logic [31:0]   r_delay, r_period, r_tid;
    logic [stt_pkg::TIME_W-1:0] r_now, n_now;
    logic [31:0]   r_idc, n_idc;
    logic          r_done, n_done;   // add placed / delete found
    // one pending expiry held so last_result can be set on the final one
    logic          r_pend, n_pend;
    logic [31:0]   r_pid, n_pid;
    logic          r_prel, n_prel;

    logic [31:0] w_nid;
    logic        w_last;

    assign w_nid  = (r_idc + 32'd1 == 32'd0) ? 32'd1 : r_idc + 32'd1;
    assign w_last = (r_cnt == CW'(SLOTS - 1));
    assign o_busy = (r_state != stt_pkg::t_ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stt_pkg::t_ST_IDLE;
            r_cnt   <= '0;
            r_now   <= '0;
            r_idc   <= '0;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_now   <= n_now;
            r_idc   <= n_idc;
            r_done  <= n_done;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid  <= n_pid;
        r_prel <= n_prel;
        if (i_start && !o_busy) begin
            r_op     <= i_operation;
            r_delay  <= i_delay_ms;
            r_period <= i_period_ms;
            r_tid    <= i_timer_id;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_now = r_now;
        n_idc = r_idc;
        n_done = r_done;
        n_pend = r_pend;
        n_pid = r_pid;
        n_prel = r_prel;
        o_tail = i_head;
        o_shift = 1'b0;
        o_strobe = 1'b0;
        o_kind = stt_pkg::KIND_ADD;
        o_result_id = '0;
        o_success = 1'b0;
        o_reloaded = 1'b0;
        o_last_result = 1'b0;
        case (r_state)
            stt_pkg::t_ST_IDLE: begin
                if (i_start && i_operation != stt_pkg::t_OP_NONE) begin
                    n_state = stt_pkg::t_ST_SCAN;
                    n_cnt = '0;
                    n_done = 1'b0;
                    n_pend = 1'b0;
                    if (i_operation == stt_pkg::t_OP_TICK) begin
                        n_now = r_now + 48'd1;
                    end
                end
            end
            stt_pkg::t_ST_SCAN: begin
                o_shift = 1'b1;
                n_cnt = r_cnt + CW'(1);
                if (w_last) begin
                    n_state = stt_pkg::t_ST_DONE;
                end
                case (r_op)
                    stt_pkg::t_OP_ADD: begin
                        if (!r_done && !i_head.valid) begin
                            n_done = 1'b1;
                            n_idc = w_nid;
                            o_tail.valid = 1'b1;
                            o_tail.id = w_nid;
                            o_tail.deadline = r_now + {16'd0, r_delay};
                            o_tail.period = r_period;
                        end
                    end
                    stt_pkg::t_OP_DEL: begin
                        if (!r_done && i_head.valid && i_head.id == r_tid) begin
                            n_done = 1'b1;
                            o_tail.valid = 1'b0;
                        end
                    end
                    default: begin
                        if (i_head.valid && i_head.deadline < r_now) begin
                            if (i_head.period != 32'd0) begin
                                o_tail.deadline = i_head.deadline
                                    + {16'd0, i_head.period};
                            end else begin
                                o_tail.valid = 1'b0;
                            end
                            if (r_pend) begin
                                o_strobe = 1'b1;
                                o_kind = stt_pkg::KIND_EXP;
                                o_result_id = r_pid;
                                o_success = 1'b1;
                                o_reloaded = r_prel;
                            end
                            n_pend = 1'b1;
                            n_pid = i_head.id;
                            n_prel = (i_head.period != 32'd0);
                        end
                    end
                endcase
            end
            stt_pkg::t_ST_DONE: begin
                n_state = stt_pkg::t_ST_IDLE;
                o_strobe = 1'b1;
                o_last_result = 1'b1;
                case (r_op)
                    stt_pkg::t_OP_ADD: begin
                        o_kind = stt_pkg::KIND_ADD;
                        o_result_id = r_done ? r_idc : 32'd0;
                        o_success = r_done;
                    end
                    stt_pkg::t_OP_DEL: begin
                        o_kind = stt_pkg::KIND_DEL;
                        o_result_id = r_tid;
                        o_success = r_done;
                    end
                    default: begin
                        if (r_pend) begin
                            o_kind = stt_pkg::KIND_EXP;
                            o_result_id = r_pid;
                            o_success = 1'b1;
                            o_reloaded = r_prel;
                        end else begin
                            o_kind = stt_pkg::KIND_EMPTY;
                        end
                    end
                endcase
            end
            default: n_state = stt_pkg::t_ST_IDLE;
        endcase
    end
endmodule

/* rtl/software_timer_table_top.sv */
// Top level: software timer table built as a rotating ring of slot cells.
//
//  channel   handshake                 payload
//  command   i_start, o_busy           i_operation, i_delay_ms, i_period_ms, i_timer_id
//  result    o_strobe (one cycle)      o_kind, o_result_id, o_success, o_reloaded,
//                                      o_last_result
//
// Every accepted add, delete or tick keeps o_busy high while the ring rotates
// a full turn past the controller head and while the final result is given.
// An expiry is held until the next one fires or the final cycle, so
// last_result marks the final one. Operation 3 is dropped at once.
// Reset clears slot valid bits (by one rotation-free clear), time and ids.
// The receiver cannot stall; o_busy holds off new commands.
module software_timer_table_top #(
    parameter int unsigned TIMER_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_delay_ms,
    input  logic [31:0] i_period_ms,
    input  logic [31:0] i_timer_id,
    output logic        o_busy,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [31:0] o_result_id,
    output logic        o_success,
    output logic        o_reloaded,
    output logic        o_last_result
);
    stt_pkg::t_slot w_ring [TIMER_SLOTS+1];
    stt_pkg::t_slot w_tail;
    logic           w_shift;

    // reset forces the valid bit of every slot low as it enters its cell
    stt_pkg::t_slot w_in [TIMER_SLOTS];

    stt_ctrl #(.SLOTS(TIMER_SLOTS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_operation  (i_operation),
        .i_delay_ms   (i_delay_ms),
        .i_period_ms  (i_period_ms),
        .i_timer_id   (i_timer_id),
        .i_head       (w_ring[0]),
        .o_tail       (w_tail),
        .o_shift      (w_shift),
        .o_busy       (o_busy),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_result_id  (o_result_id),
        .o_success    (o_success),
        .o_reloaded   (o_reloaded),
        .o_last_result(o_last_result)
    );

    assign w_ring[TIMER_SLOTS] = w_tail;

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        always_comb begin
            w_in[g] = i_rst_n ? w_ring[g+1] : w_ring[g];
            if (!i_rst_n) begin
                w_in[g].valid = 1'b0;
            end
        end
        stt_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_shift || !i_rst_n),
            .i_slot (w_in[g]),
            .o_slot (w_ring[g])
        );
    end
endmodule

/* bench/tb_software_timer_table_top.sv */
// Self-checking testbench for the software timer table: add, delete and tick traffic.
module tb_software_timer_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 16;
    localparam int CYC_LIMIT  = 400000;
    localparam logic [47:0] T_MASK = 48'hFFFF_FFFF_FFFF;

    // one result as the block reports it
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] rid;
        logic        ok;
        logic        rel;
        logic        last;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [1:0]  i_operation;
    logic [31:0] i_delay_ms;
    logic [31:0] i_period_ms;
    logic [31:0] i_timer_id;
    logic        o_busy;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [31:0] o_result_id;
    logic        o_success;
    logic        o_reloaded;
    logic        o_last_result;

    software_timer_table_top #(.TIMER_SLOTS(SLOTS)) dut (.*);

    // 20 ns clock
    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    // timer table mirror
    logic        tbl_valid [SLOTS];
    logic [31:0] tbl_id    [SLOTS];
    logic [47:0] tbl_dl    [SLOTS];
    logic [31:0] tbl_per   [SLOTS];
    logic [47:0] clock_ms;
    logic [31:0] last_id;

    t_reply pending_replies[$];
    int     mismatches;
    int     replies_seen;
    int     expiries_seen;
    int     cycles;
    int     idle_pct;      // chance in 100, drawn again at each try, that the sender idles before a command
    int     live_ids[$];   // ids most likely still in the table

    function automatic t_reply mk(logic [1:0] k, logic [31:0] id, logic ok,
                                  logic rel, logic last);
        t_reply r;
        r.kind = k; r.rid = id; r.ok = ok; r.rel = rel; r.last = last;
        return r;
    endfunction

    // append one expected result
    task automatic expect_reply(t_reply r);
        pending_replies = {pending_replies, r};
    endtask

    // advance the mirror by one command and queue what the block must report
    task automatic predict_command(logic [1:0] op, logic [31:0] dly, logic [31:0] per,
                                   logic [31:0] tid);
        int     n;
        bit     done;
        t_reply r;
        done = 0;
        n = 0;
        case (op)
            stt_pkg::t_OP_ADD: begin
                for (int i = 0; i < SLOTS && !done; i++) begin
                    if (!tbl_valid[i]) begin
                        last_id = last_id + 32'd1;
                        if (last_id == 32'd0) last_id = 32'd1;
                        tbl_valid[i] = 1'b1;
                        tbl_id[i]    = last_id;
                        tbl_dl[i]    = (clock_ms + {16'd0, dly}) & T_MASK;
                        tbl_per[i]   = per;
                        expect_reply(mk(stt_pkg::KIND_ADD, last_id, 1'b1, 1'b0, 1'b1));
                        live_ids = {live_ids, int'(last_id)};
                        done = 1;
                    end
                end
                if (!done) expect_reply(mk(stt_pkg::KIND_ADD, 32'd0, 1'b0, 1'b0, 1'b1));
            end
            stt_pkg::t_OP_DEL: begin
                for (int i = 0; i < SLOTS && !done; i++) begin
                    if (tbl_valid[i] && tbl_id[i] == tid) begin
                        tbl_valid[i] = 1'b0;
                        done = 1;
                    end
                end
                expect_reply(mk(stt_pkg::KIND_DEL, tid, done, 1'b0, 1'b1));
            end
            stt_pkg::t_OP_TICK: begin
                clock_ms = (clock_ms + 48'd1) & T_MASK;
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_dl[i] < clock_ms) begin
                        r = mk(stt_pkg::KIND_EXP, tbl_id[i], 1'b1, tbl_per[i] != 0, 1'b0);
                        if (tbl_per[i] != 0)
                            tbl_dl[i] = (tbl_dl[i] + {16'd0, tbl_per[i]}) & T_MASK;
                        else
                            tbl_valid[i] = 1'b0;
                        expect_reply(r);
                        n++;
                    end
                end
                if (n == 0) expect_reply(mk(stt_pkg::KIND_EMPTY, 32'd0, 1'b0, 1'b0, 1'b1));
                else pending_replies[$].last = 1'b1;
            end
            default: ; // operation 3 is dropped without a result
        endcase
    endtask

    // one command transfer, with optional random idle cycles in front
    task automatic send_command(logic [1:0] op, logic [31:0] dly, logic [31:0] per,
                                logic [31:0] tid);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        i_start     <= 1'b1;
        i_operation <= op;
        i_delay_ms  <= dly;
        i_period_ms <= per;
        i_timer_id  <= tid;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        // the transfer happened at this edge
        predict_command(op, dly, per, tid);
        i_start     <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off until the block has reported everything
    task automatic drain;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);
    endtask

    task automatic add_timer(logic [31:0] dly, logic [31:0] per);
        send_command(stt_pkg::t_OP_ADD, dly, per, $urandom);
    endtask

    task automatic tick;
        send_command(stt_pkg::t_OP_TICK, $urandom, $urandom, $urandom);
    endtask

    // result checker: every strobe is one transfer
    always @(posedge i_clk) begin
        t_reply got, want;
        if (i_rst_n && o_strobe) begin
            got = mk(o_kind, o_result_id, o_success, o_reloaded, o_last_result);
            replies_seen++;
            if (o_kind == stt_pkg::KIND_EXP) expiries_seen++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d id=%h", o_kind, o_result_id);
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind=%0d id=%h ok=%b rel=%b last=%b,",
                                  " got kind=%0d id=%h ok=%b rel=%b last=%b"},
                                 want.kind, want.rid, want.ok, want.rel, want.last,
                                 got.kind, got.rid, got.ok, got.rel, got.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // directed: one-shot, periodic, extremes, delete corners, unknown opcode
    task automatic test_directed;
        add_timer(32'd0, 32'd0);            // fires on first tick
        add_timer(32'd1, 32'd2);            // periodic
        add_timer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_timer(32'd0, 32'hFFFF_FFFF);
        tick; tick; tick;
        // id 0 never matches
        send_command(stt_pkg::t_OP_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_command(stt_pkg::t_OP_DEL, 32'd0, 32'd0, 32'hFFFF_FFFF);   // absent id
        send_command(stt_pkg::t_OP_DEL, 32'd0, 32'd0, 32'd2);           // periodic one
        send_command(stt_pkg::t_OP_DEL, 32'd0, 32'd0, 32'd2);           // already gone
        send_command(stt_pkg::t_OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        tick;
        // fill the table; the last two adds find no free slot
        for (int i = 0; i < SLOTS; i++) add_timer(32'd5 + i, i[0] ? 32'd0 : 32'd1);
        tick;
        repeat (6) tick;   // several expiries per tick, reloads
    endtask

    // random traffic: mostly valid adds/deletes/ticks with short delays
    task automatic test_random(int count);
        int          pick, k;
        logic [31:0] dly, per, tid;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            dly  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(12);
            per  = ($urandom_range(2) == 0) ? 32'd0 :
                   ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 6);
            if (pick < 35) add_timer(dly, per);
            else if (pick < 55) begin
                if (live_ids.size() != 0 && $urandom_range(3) != 0) begin
                    k = $urandom_range(live_ids.size() - 1);
                    tid = live_ids[k];
                    live_ids.delete(k);
                end else tid = $urandom;
                send_command(stt_pkg::t_OP_DEL, $urandom, $urandom, tid);
            end else if (pick < 97) tick;
            else send_command(stt_pkg::t_OP_NONE, $urandom, $urandom, $urandom);
            if (live_ids.size() > 40) live_ids.pop_front();
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_start = 1'b0; i_operation = stt_pkg::t_OP_NONE;
        i_delay_ms = '0; i_period_ms = '0; i_timer_id = '0;
        mismatches = 0; replies_seen = 0; expiries_seen = 0; cycles = 0;
        idle_pct = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 0; tbl_id[i] = 0; tbl_dl[i] = 0; tbl_per[i] = 0;
        end
        clock_ms = '0; last_id = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);   // allow for the reset clear

        test_directed;
        drain;                              // sender waits for every result
        idle_pct = 0;  test_random(108);
        idle_pct = 76; test_random(108);
        idle_pct = 19; test_random(108);
        drain;

        $display("covered %0d results, %0d expiries, directed corners and three idle phases",
                 replies_seen, expiries_seen);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* files.f */
rtl/stt_pkg.sv
rtl/stt_cell.sv
rtl/stt_ctrl.sv
rtl/software_timer_table_top.sv
bench/tb_software_timer_table_top.sv
